// ===== rtl/core/gse_pkg.sv =====
`timescale 1ns / 1ps

package gse_pkg;

    localparam int SectorBytes = 524;
    localparam logic [9:0] LastPos = 10'(SectorBytes - 1);

    localparam logic [2:0] GroupLastIdx = 3'd3;
    localparam logic [2:0] TailLastIdx  = 3'd6;

    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    typedef enum logic {
        JOB_GROUP,
        JOB_TAIL
    } job_kind_t;

    // one unit of work for the back end: a byte triplet or the sector tail
    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] first;
        logic [7:0] second;
        logic [7:0] third;
        logic [7:0] chk_a;
        logic [7:0] chk_b;
        logic [7:0] chk_c;
    } job_t;

    localparam logic [7:0] GcrTable [64] = '{
        8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
        8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
        8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
        8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
        8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
        8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
        8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
        8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
    };

    function automatic logic [7:0] gcr_xlat(input logic [5:0] six);
        return GcrTable[six];
    endfunction

    // six-bit value of nibble idx within a job
    function automatic logic [5:0] nib_six(input job_t j, input logic [2:0] idx);
        logic [5:0] r;
        r = 6'd0;
        case (idx)
            3'd0:
            begin
                if (j.kind == JOB_TAIL)
                    r = {j.first[7:6], j.second[7:6], 2'b00};
                else
                    r = {j.first[7:6], j.second[7:6], j.third[7:6]};
            end
            3'd1: r = j.first[5:0];
            3'd2: r = j.second[5:0];
            3'd3:
            begin
                if (j.kind == JOB_TAIL)
                    r = {j.chk_c[7:6], j.chk_b[7:6], j.chk_a[7:6]};
                else
                    r = j.third[5:0];
            end
            3'd4: r = j.chk_c[5:0];
            3'd5: r = j.chk_b[5:0];
            3'd6: r = j.chk_a[5:0];
            default: r = 6'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/core/gse_front.sv =====
`timescale 1ns / 1ps

module gse_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          byte_valid,
    output logic          byte_stall,
    input  logic [7:0]    data_byte,
    input  logic          q_full,
    output logic          q_push,
    output gse_pkg::job_t q_job
);
    import gse_pkg::*;

    logic [7:0] sum_a_reg, sum_a_next;
    logic [8:0] sum_b_reg, sum_b_next;
    logic [8:0] sum_c_reg, sum_c_next;
    logic [7:0] first_reg, first_next;
    logic [7:0] second_reg, second_next;
    logic [9:0] pos_reg, pos_next;
    phase_t     phase_reg, phase_next;

    logic       need_push;
    logic       accept;
    logic       is_last;
    logic [7:0] rot;
    logic [7:0] x_second;
    logic [7:0] x_third;

    assign is_last   = (pos_reg == LastPos);
    assign need_push = (phase_reg == PH_THIRD) || (phase_reg == PH_SECOND && is_last);
    assign byte_stall = need_push && q_full;
    assign accept    = byte_valid && !byte_stall;
    assign q_push    = accept && need_push;

    // rotate left, the top bit wraps in and also carries into sum_c
    assign rot      = {sum_a_reg[6:0], sum_a_reg[7]};
    assign x_second = data_byte ^ sum_c_reg[7:0];
    assign x_third  = data_byte ^ sum_b_reg[7:0];

    always_comb
    begin
        sum_a_next  = sum_a_reg;
        sum_b_next  = sum_b_reg;
        sum_c_next  = sum_c_reg;
        first_next  = first_reg;
        second_next = second_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        q_job       = '0;
        q_job.kind  = JOB_GROUP;
        q_job.first  = first_reg;
        q_job.second = second_reg;
        q_job.third  = x_third;
        if (accept)
        begin
            pos_next = pos_reg + 10'd1;
            unique case (phase_reg)
                PH_FIRST:
                begin
                    sum_a_next = rot;
                    sum_c_next = {1'b0, sum_c_reg[7:0]} + {1'b0, data_byte}
                                 + 9'(sum_a_reg[7]);
                    first_next = data_byte ^ rot;
                    phase_next = PH_SECOND;
                end
                PH_SECOND:
                begin
                    sum_b_next  = {1'b0, sum_b_reg[7:0]} + {1'b0, data_byte}
                                  + 9'(sum_c_reg[8]);
                    sum_c_next  = {1'b0, sum_c_reg[7:0]};
                    second_next = x_second;
                    phase_next  = PH_THIRD;
                    q_job.kind   = JOB_TAIL;
                    q_job.second = x_second;
                    q_job.third  = 8'd0;
                    q_job.chk_a  = sum_a_reg;
                    q_job.chk_b  = sum_b_next[7:0];
                    q_job.chk_c  = sum_c_reg[7:0];
                    if (is_last)
                    begin
                        // sector done, back to the starting state
                        sum_a_next = '0;
                        sum_b_next = '0;
                        sum_c_next = '0;
                        pos_next   = '0;
                        phase_next = PH_FIRST;
                    end
                end
                PH_THIRD:
                begin
                    sum_a_next = sum_a_reg + data_byte + 8'(sum_b_reg[8]);
                    sum_b_next = {1'b0, sum_b_reg[7:0]};
                    phase_next = PH_FIRST;
                end
                default:
                begin
                    phase_next = PH_FIRST;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            sum_c_reg <= '0;
            pos_reg   <= '0;
            phase_reg <= PH_FIRST;
        end
        else
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            sum_c_reg <= sum_c_next;
            pos_reg   <= pos_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        first_reg  <= first_next;
        second_reg <= second_next;
    end

endmodule

// ===== rtl/core/gse_queue.sv =====
`timescale 1ns / 1ps

module gse_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  gse_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output gse_pkg::job_t head_job,
    output logic          head_valid
);
    import gse_pkg::*;

    localparam int PtrW = $clog2(QueueDepth);

    job_t              mem [QueueDepth];
    logic [PtrW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PtrW:0]     count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = (count_reg == (PtrW + 1)'(QueueDepth));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + (PtrW + 1)'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - (PtrW + 1)'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_job;
    end

endmodule

// ===== rtl/core/gse_back.sv =====
`timescale 1ns / 1ps

module gse_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  gse_pkg::job_t q_job,
    output logic          q_pop,
    output logic          nibble_valid,
    input  logic          nibble_stall,
    output logic [7:0]    disk_nibble,
    output logic          end_of_run,
    output logic          end_of_sector
);
    import gse_pkg::*;

    logic       job_valid_reg, job_valid_next;
    job_t       job_reg, job_next;
    logic [2:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] nibble_reg, nibble_next;
    logic       eor_reg, eor_next;
    logic       eos_reg, eos_next;

    logic       out_free;
    logic       emit;
    logic       at_last;
    logic       load;
    logic [2:0] last_idx;

    assign last_idx = (job_reg.kind == JOB_TAIL) ? TailLastIdx : GroupLastIdx;
    assign out_free = !out_valid_reg || !nibble_stall;
    assign emit     = job_valid_reg && out_free;
    assign at_last  = (idx_reg == last_idx);
    // take the next job as the current one hands over its last word
    assign load     = q_valid && (!job_valid_reg || (emit && at_last));
    assign q_pop    = load;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        idx_next       = idx_reg;
        if (load)
        begin
            job_valid_next = 1'b1;
            job_next       = q_job;
            idx_next       = '0;
        end
        else if (emit && at_last)
            job_valid_next = 1'b0;
        else if (emit)
            idx_next = idx_reg + 3'd1;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        nibble_next    = nibble_reg;
        eor_next       = eor_reg;
        eos_next       = eos_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            nibble_next    = gcr_xlat(nib_six(job_reg, idx_reg));
            eor_next       = at_last;
            eos_next       = at_last && (job_reg.kind == JOB_TAIL);
        end
        else if (!nibble_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        nibble_reg <= nibble_next;
        eor_reg    <= eor_next;
        eos_reg    <= eos_next;
    end

    assign nibble_valid  = out_valid_reg;
    assign disk_nibble   = nibble_reg;
    assign end_of_run    = eor_reg;
    assign end_of_sector = eos_reg;

endmodule

// ===== rtl/core/gcr62_sector_encoder_35_unit.sv =====
`timescale 1ns / 1ps
// a taken triplet's nibbles pass the queue, the back end job register and the output register
// throughput: one byte per cycle in unless byte_stall, one nibble per cycle out unless
// nibble_stall; output sets the pace; a 524-byte sector: 4 nibbles per 3 bytes plus tail
// a 2-entry job queue sits between the checksum front end and the nibble back end
// reset: async active low, clears checksums, byte count, queue and output valid
module gcr62_sector_encoder_35_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    output logic       nibble_valid,
    input  logic       nibble_stall,
    output logic [7:0] disk_nibble,
    output logic       end_of_run,
    output logic       end_of_sector
);
    import gse_pkg::*;

    logic q_full;
    logic q_push;
    job_t push_job;
    logic q_pop;
    job_t head_job;
    logic head_valid;

    gse_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    gse_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    gse_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (head_valid),
        .q_job         (head_job),
        .q_pop         (q_pop),
        .nibble_valid  (nibble_valid),
        .nibble_stall  (nibble_stall),
        .disk_nibble   (disk_nibble),
        .end_of_run    (end_of_run),
        .end_of_sector (end_of_sector)
    );

endmodule
